### rtl/cbcm_pkg.sv
// Shared types, constants and helpers for the cylinder block coordinate map.
// Depends on nothing; every other file of the block imports it.
package cbcm_pkg;

    localparam int LFB      = 16;          // logical fraction bits
    localparam int LW       = LFB + 1;     // clamped logical value width
    localparam int TW       = LW + 1;      // signed offset from one half
    localparam int CW       = 33;          // datapath word, signed
    localparam int PW       = 51;          // front and blend product width
    localparam int MW       = 66;          // rotation product width
    localparam int SW       = 35;          // pre-saturation sum width
    localparam int DIV_BITS = 32;          // quotient bits of r0
    localparam int DW       = 61;          // dividend width
    localparam int RW       = 31;          // divisor and remainder width
    localparam int CFG_W    = 32;
    localparam int IDX_W    = 3;
    localparam int BLK_W    = 3;

    localparam logic [LW-1:0] ONE  = LW'(1) << LFB;
    localparam logic [LW-1:0] HALF = LW'(1) << (LFB - 1);

    localparam logic signed [PW-1:0] HALF_PI_Q30 = PW'(1686629713);
    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

    localparam logic [BLK_W-1:0] BLK_INNER   = 3'd0;
    localparam logic [BLK_W-1:0] BLK_MINUS_X = 3'd1;
    localparam logic [BLK_W-1:0] BLK_PLUS_X  = 3'd2;
    localparam logic [BLK_W-1:0] BLK_MINUS_Y = 3'd3;
    localparam logic [BLK_W-1:0] BLK_PLUS_Y  = 3'd4;

    localparam logic [IDX_W-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [IDX_W-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [IDX_W-1:0] CFG_CENTER_Z = 3'd2;
    localparam logic [IDX_W-1:0] CFG_RADIUS   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_LENGTH   = 3'd4;
    localparam logic [IDX_W-1:0] CFG_BLOCK    = 3'd5;

    typedef struct packed {
        logic [LW-1:0]        sw;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] bz;
        logic signed [CW-1:0] cs;
        logic signed [CW-1:0] sn;
    } t_side;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               sat;
    } t_result;

    function automatic logic signed [CW-1:0] atan_q30(input int idx);
        logic signed [CW-1:0] a;
        case (idx)
            0:  a = CW'(843314857);
            1:  a = CW'(497837829);
            2:  a = CW'(263043836);
            3:  a = CW'(133525158);
            4:  a = CW'(67021686);
            5:  a = CW'(33543515);
            6:  a = CW'(16775850);
            7:  a = CW'(8388437);
            8:  a = CW'(4194282);
            9:  a = CW'(2097149);
            10: a = CW'(1048575);
            11: a = CW'(524287);
            12: a = CW'(262143);
            13: a = CW'(131071);
            14: a = CW'(65535);
            15: a = CW'(32767);
            16: a = CW'(16383);
            17: a = CW'(8191);
            18: a = CW'(4095);
            19: a = CW'(2047);
            20: a = CW'(1023);
            21: a = CW'(511);
            22: a = CW'(255);
            23: a = CW'(127);
            24: a = CW'(63);
            25: a = CW'(31);
            26: a = CW'(15);
            27: a = CW'(8);
            28: a = CW'(4);
            29: a = CW'(2);
            default: a = '0;
        endcase
        return a;
    endfunction

    // {clipped, value}
    function automatic logic [32:0] sat32(input logic signed [SW-1:0] v);
        logic [32:0] r;
        if (v > SW'(64'sd2147483647)) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -SW'(64'sd2147483648)) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

### rtl/cbcm_front.sv
// Front stages: input clamp, angle and weight select, linear products, angle and base-position rounding.
// Depends on cbcm_pkg.
module cbcm_front import cbcm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [LW-1:0]        i_xi_u,
    input  logic [LW-1:0]        i_xi_v,
    input  logic [LW-1:0]        i_xi_w,
    input  logic [30:0]          i_radius,
    input  logic [30:0]          i_length,
    input  logic signed [31:0]   i_center_x,
    input  logic signed [31:0]   i_center_y,
    input  logic signed [31:0]   i_center_z,
    input  logic [BLK_W-1:0]     i_block_select,
    output logic                 o_valid,
    output logic signed [CW-1:0] o_theta,
    output t_side                o_side
);

    localparam logic signed [PW-1:0] RND0 = PW'(1) << (LFB - 1);
    localparam logic signed [PW-1:0] RND1 = PW'(1) << LFB;

    logic [LW-1:0]        n_cu, n_cv, n_cw, n_tr, n_sw;
    logic signed [TW-1:0] n_t;

    logic                 r1_v;
    logic [LW-1:0]        r1_u, r1_vv, r1_w, r1_sw;
    logic signed [TW-1:0] r1_t;

    logic                 r2_v;
    logic [LW-1:0]        r2_sw;
    logic signed [PW-1:0] r2_pt, r2_pu, r2_pv, r2_pw;

    logic                 r3_v;
    logic signed [CW-1:0] r3_theta;
    t_side                r3_side;

    logic signed [TW-1:0] du, dv, dw;
    logic signed [PW-1:0] rs, ls;

    always_comb begin
        n_cu = (i_xi_u > ONE) ? ONE : i_xi_u;
        n_cv = (i_xi_v > ONE) ? ONE : i_xi_v;
        n_cw = (i_xi_w > ONE) ? ONE : i_xi_w;
        if (i_block_select == BLK_MINUS_X || i_block_select == BLK_PLUS_X) begin
            n_tr = n_cv;
            n_sw = n_cu;
        end else begin
            n_tr = n_cu;
            n_sw = n_cv;
        end
        if (i_block_select == BLK_MINUS_X || i_block_select == BLK_PLUS_Y) begin
            n_t = $signed({1'b0, HALF}) - $signed({1'b0, n_tr});
        end else begin
            n_t = $signed({1'b0, n_tr}) - $signed({1'b0, HALF});
        end
    end

    always_comb begin
        du = $signed({1'b0, r1_u})  - $signed({1'b0, HALF});
        dv = $signed({1'b0, r1_vv}) - $signed({1'b0, HALF});
        dw = $signed({1'b0, r1_w})  - $signed({1'b0, HALF});
        rs = $signed({{(PW-31){1'b0}}, i_radius});
        ls = $signed({{(PW-31){1'b0}}, i_length});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_u  <= n_cu;
            r1_vv <= n_cv;
            r1_w  <= n_cw;
            r1_sw <= n_sw;
            r1_t  <= n_t;

            r2_sw <= r1_sw;
            r2_pt <= PW'(r1_t) * HALF_PI_Q30;
            r2_pu <= rs * PW'(du);
            r2_pv <= rs * PW'(dv);
            r2_pw <= ls * PW'(dw);

            r3_theta   <= CW'((r2_pt + RND0) >>> LFB);
            r3_side.sw <= r2_sw;
            r3_side.bx <= CW'(i_center_x) + CW'((r2_pu + RND1) >>> (LFB + 1));
            r3_side.by <= CW'(i_center_y) + CW'((r2_pv + RND1) >>> (LFB + 1));
            r3_side.bz <= CW'(i_center_z) + CW'((r2_pw + RND0) >>> LFB);
            r3_side.cs <= '0;
            r3_side.sn <= '0;
        end
    end

    assign o_valid = r3_v;
    assign o_theta = r3_theta;
    assign o_side  = r3_side;

endmodule

### rtl/cbcm_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per register stage.
// Depends on cbcm_pkg (angle table, side payload type).
module cbcm_cordic import cbcm_pkg::*; #(
    parameter int STAGES = 18
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [CW-1:0] i_theta,
    input  t_side                i_side,
    output logic                 o_valid,
    output t_side                o_side
);

    localparam int NS = (STAGES < 30) ? STAGES : 30;

    logic                 r_v    [NS];
    logic signed [CW-1:0] r_x    [NS];
    logic signed [CW-1:0] r_y    [NS];
    logic signed [CW-1:0] r_z    [NS];
    t_side                r_side [NS];

    for (genvar g = 0; g < NS; g++) begin : g_stage
        logic                 a_v;
        logic signed [CW-1:0] a_x, a_y, a_z;
        t_side                a_side;
        logic signed [CW-1:0] n_x, n_y, n_z;

        if (g == 0) begin : g_first
            assign a_v    = i_valid;
            assign a_x    = CORDIC_GAIN;
            assign a_y    = '0;
            assign a_z    = i_theta;
            assign a_side = i_side;
        end else begin : g_next
            assign a_v    = r_v[g-1];
            assign a_x    = r_x[g-1];
            assign a_y    = r_y[g-1];
            assign a_z    = r_z[g-1];
            assign a_side = r_side[g-1];
        end

        always_comb begin
            if (a_z >= 0) begin
                n_x = a_x - (a_y >>> g);
                n_y = a_y + (a_x >>> g);
                n_z = a_z - atan_q30(g);
            end else begin
                n_x = a_x + (a_y >>> g);
                n_y = a_y - (a_x >>> g);
                n_z = a_z + atan_q30(g);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= a_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g]    <= n_x;
                r_y[g]    <= n_y;
                r_z[g]    <= n_z;
                r_side[g] <= a_side;
            end
        end
    end

    always_comb begin
        o_side    = r_side[NS-1];
        o_side.cs = (r_x[NS-1] < 1) ? CW'(1) : r_x[NS-1];
        o_side.sn = r_y[NS-1];
    end

    assign o_valid = r_v[NS-1];

endmodule

### rtl/cbcm_div.sv
// Pipelined restoring divider for r0 = round(R * 2^29 / cos), one quotient bit per stage.
// Depends on cbcm_pkg.
module cbcm_div import cbcm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  t_side               i_side,
    input  logic [30:0]         i_radius,
    output logic                o_valid,
    output logic [DIV_BITS-1:0] o_r0,
    output t_side               o_side
);

    logic [RW-1:0] n_cc;
    logic [DW-1:0] n_num;

    logic                r0_v;
    logic [RW-1:0]       r0_cc, r0_rem;
    logic [DIV_BITS-1:0] r0_lo;
    t_side               r0_side;

    logic                r_v    [DIV_BITS];
    logic [RW-1:0]       r_cc   [DIV_BITS];
    logic [RW-1:0]       r_rem  [DIV_BITS];
    logic [DIV_BITS-1:0] r_lo   [DIV_BITS];
    logic [DIV_BITS-1:0] r_q    [DIV_BITS];
    t_side               r_side [DIV_BITS];

    always_comb begin
        n_cc  = RW'(i_side.cs);
        n_num = DW'({i_radius, 29'b0}) + DW'(n_cc >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (i_en) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_cc   <= n_cc;
            r0_rem  <= RW'(n_num[DW-1:DIV_BITS]);
            r0_lo   <= n_num[DIV_BITS-1:0];
            r0_side <= i_side;
        end
    end

    for (genvar k = 0; k < DIV_BITS; k++) begin : g_bit
        logic                a_v;
        logic [RW-1:0]       a_cc, a_rem;
        logic [DIV_BITS-1:0] a_lo, a_q;
        t_side               a_side;
        logic [RW:0]         sh;
        logic                ge;

        if (k == 0) begin : g_first
            assign a_v    = r0_v;
            assign a_cc   = r0_cc;
            assign a_rem  = r0_rem;
            assign a_lo   = r0_lo;
            assign a_q    = '0;
            assign a_side = r0_side;
        end else begin : g_next
            assign a_v    = r_v[k-1];
            assign a_cc   = r_cc[k-1];
            assign a_rem  = r_rem[k-1];
            assign a_lo   = r_lo[k-1];
            assign a_q    = r_q[k-1];
            assign a_side = r_side[k-1];
        end

        assign sh = {a_rem, a_lo[DIV_BITS-1-k]};
        assign ge = (sh >= {1'b0, a_cc});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= a_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cc[k]   <= a_cc;
                r_rem[k]  <= ge ? RW'(sh - {1'b0, a_cc}) : sh[RW-1:0];
                r_lo[k]   <= a_lo;
                r_q[k]    <= {a_q[DIV_BITS-2:0], ge};
                r_side[k] <= a_side;
            end
        end
    end

    assign o_valid = r_v[DIV_BITS-1];
    assign o_r0    = r_q[DIV_BITS-1];
    assign o_side  = r_side[DIV_BITS-1];

endmodule

### rtl/cbcm_back.sv
// Back stages: radius blend, quadrant rotation, offset rounding, block select, saturation.
// Depends on cbcm_pkg.
module cbcm_back import cbcm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [DIV_BITS-1:0] i_r0,
    input  t_side               i_side,
    input  logic [30:0]         i_radius,
    input  logic signed [31:0]  i_center_x,
    input  logic signed [31:0]  i_center_y,
    input  logic [BLK_W-1:0]    i_block_select,
    output logic                o_valid,
    output t_result             o_result
);

    localparam logic signed [PW-1:0] RND_L = PW'(1) << (LFB - 1);
    localparam logic signed [MW-1:0] RND_T = MW'(1) << 29;

    logic signed [CW-1:0] rad_s, n_d;

    logic                 r1_v;
    logic signed [PW-1:0] r1_pm;
    t_side                r1_side;

    logic                 r2_v;
    logic signed [CW-1:0] r2_rad, r2_cp, r2_sp;
    t_side                r2_side;

    logic                 r3_v;
    logic signed [MW-1:0] r3_mx, r3_my;
    t_side                r3_side;

    logic signed [CW-1:0] n_cp, n_sp;
    logic signed [SW-1:0] px, py, pz;
    logic [32:0]          sx, sy, sz;
    logic                 trig;

    always_comb begin
        rad_s = $signed({2'b0, i_radius});
        n_d   = rad_s - $signed({1'b0, i_r0});
    end

    always_comb begin
        unique case (i_block_select)
            BLK_MINUS_X: begin
                n_cp = -r1_side.cs;
                n_sp = -r1_side.sn;
            end
            BLK_PLUS_X: begin
                n_cp = r1_side.cs;
                n_sp = r1_side.sn;
            end
            BLK_MINUS_Y: begin
                n_cp = r1_side.sn;
                n_sp = -r1_side.cs;
            end
            default: begin
                n_cp = -r1_side.sn;
                n_sp = r1_side.cs;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pm   <= PW'($signed({1'b0, i_side.sw})) * PW'(n_d);
            r1_side <= i_side;

            r2_rad  <= rad_s - CW'((r1_pm + RND_L) >>> LFB);
            r2_cp   <= n_cp;
            r2_sp   <= n_sp;
            r2_side <= r1_side;

            r3_mx   <= MW'(r2_rad) * MW'(r2_cp);
            r3_my   <= MW'(r2_rad) * MW'(r2_sp);
            r3_side <= r2_side;
        end
    end

    always_comb begin
        trig = (i_block_select >= BLK_MINUS_X) && (i_block_select <= BLK_PLUS_Y);
        if (trig) begin
            px = SW'(i_center_x) + SW'((r3_mx + RND_T) >>> 30);
            py = SW'(i_center_y) + SW'((r3_my + RND_T) >>> 30);
        end else begin
            px = SW'(r3_side.bx);
            py = SW'(r3_side.by);
        end
        pz = SW'(r3_side.bz);
        sx = sat32(px);
        sy = sat32(py);
        sz = sat32(pz);
        o_result.x   = sx[31:0];
        o_result.y   = sy[31:0];
        o_result.z   = sz[31:0];
        o_result.sat = sx[32] | sy[32] | sz[32];
    end

    assign o_valid = r3_v;

endmodule

### rtl/cylinder_block_coordinate_map.sv
// Top level of the five-block cylinder coordinate map: configuration registers,
// pipeline of front, CORDIC, divider and back stages, output register with skid.
// Depends on cbcm_pkg, cbcm_front, cbcm_cordic, cbcm_div, cbcm_back.
//
// Usage:
//   Input beats (i_xi_u, i_xi_v, i_xi_w) enter on i_valid/o_ready; result beats
//   (o_pos_x, o_pos_y, o_pos_z, o_saturated) leave on o_valid/i_ready.
//   Configuration writes on i_cfg_we/i_cfg_idx/i_cfg_data are registered;
//   write only while no beat is in flight. Indexes 6 and 7 are ignored.
//   Throughput: one beat per cycle while o_ready is high.
//   Pipeline: 3 front stages, TRIG_STAGES CORDIC stages (capped at the length of
//   the angle table), 33 divider stages (a setup stage and one per quotient bit
//   of the rim-to-square radius), 3 back stages and the output register.
//   Stall: while a result waits, the pipeline advances until a result enters a
//   skid register, then holds as a whole with o_ready low; nothing is dropped.
//   Reset (i_rst_n low, synchronous) clears all valid bits and sets the registers
//   to center 0, radius and length 1.0, inner block.
module cylinder_block_coordinate_map import cbcm_pkg::*; #(
    parameter int TRIG_STAGES = 18
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [LW-1:0]      i_xi_u,
    input  logic [LW-1:0]      i_xi_v,
    input  logic [LW-1:0]      i_xi_w,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic               o_saturated,
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    logic signed [31:0] r_cx, r_cy, r_cz;
    logic [30:0]        r_radius, r_length;
    logic [BLK_W-1:0]   r_blk;

    logic                 en;
    logic                 f_v, c_v, d_v, b_v;
    logic signed [CW-1:0] f_theta;
    t_side                f_side, c_side, d_side;
    logic [DIV_BITS-1:0]  d_r0;
    t_result              b_res;

    logic    r_out_v, r_skid_v;
    t_result r_out, r_skid;
    logic    take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_cz     <= '0;
            r_radius <= 31'd65536;
            r_length <= 31'd65536;
            r_blk    <= BLK_INNER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CENTER_X: r_cx     <= i_cfg_data;
                CFG_CENTER_Y: r_cy     <= i_cfg_data;
                CFG_CENTER_Z: r_cz     <= i_cfg_data;
                CFG_RADIUS:   r_radius <= i_cfg_data[30:0];
                CFG_LENGTH:   r_length <= i_cfg_data[30:0];
                CFG_BLOCK:    r_blk    <= i_cfg_data[BLK_W-1:0];
                default: ;
            endcase
        end
    end

    assign en      = !r_skid_v;
    assign o_ready = en;
    assign take    = r_out_v && i_ready;

    cbcm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (i_valid),
        .i_xi_u         (i_xi_u),
        .i_xi_v         (i_xi_v),
        .i_xi_w         (i_xi_w),
        .i_radius       (r_radius),
        .i_length       (r_length),
        .i_center_x     (r_cx),
        .i_center_y     (r_cy),
        .i_center_z     (r_cz),
        .i_block_select (r_blk),
        .o_valid        (f_v),
        .o_theta        (f_theta),
        .o_side         (f_side)
    );

    cbcm_cordic #(
        .STAGES (TRIG_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_v),
        .i_theta (f_theta),
        .i_side  (f_side),
        .o_valid (c_v),
        .o_side  (c_side)
    );

    cbcm_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (c_v),
        .i_side   (c_side),
        .i_radius (r_radius),
        .o_valid  (d_v),
        .o_r0     (d_r0),
        .o_side   (d_side)
    );

    cbcm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (d_v),
        .i_r0           (d_r0),
        .i_side         (d_side),
        .i_radius       (r_radius),
        .i_center_x     (r_cx),
        .i_center_y     (r_cy),
        .i_block_select (r_blk),
        .o_valid        (b_v),
        .o_result       (b_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (!r_out_v || take) begin
                if (r_skid_v) begin
                    r_out_v  <= 1'b1;
                    r_skid_v <= 1'b0;
                end else begin
                    r_out_v <= en && b_v;
                end
            end else if (en && b_v) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || take) begin
            if (r_skid_v) begin
                r_out <= r_skid;
            end else begin
                r_out <= b_res;
            end
        end else if (en && b_v) begin
            r_skid <= b_res;
        end
    end

    assign o_valid     = r_out_v;
    assign o_pos_x     = r_out.x;
    assign o_pos_y     = r_out.y;
    assign o_pos_z     = r_out.z;
    assign o_saturated = r_out.sat;

endmodule
